FILE: rtl/cpcd_pkg.sv
// ----------------------------------------------------------------------------
// cpcd_pkg
// Shared types, codes and denomination tables for the coin changer.
// ----------------------------------------------------------------------------
package cpcd_pkg;

  // stock counter width per denomination
  localparam int COUNT_BITS  = 16;
  localparam int NUM_SLOTS   = 8;
  localparam int SLOT_BITS   = 3;
  // paid amount, change and refund width
  localparam int AMT_BITS    = 17;
  // largest quotient is 131071 / 5
  localparam int QUO_BITS    = 15;
  localparam int GIVEN_BITS  = 16;
  // reciprocal division by a denomination
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_BITS  = 18;
  localparam int PROD_BITS   = AMT_BITS + RECIP_BITS;
  localparam int LOAD_BITS   = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam int CMP_BITS    = (COUNT_BITS > QUO_BITS) ? COUNT_BITS : QUO_BITS;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [AMT_BITS-1:0] DENOM [NUM_SLOTS] = '{
    AMT_BITS'(1000), AMT_BITS'(500), AMT_BITS'(200), AMT_BITS'(100),
    AMT_BITS'(50),   AMT_BITS'(20),  AMT_BITS'(10),  AMT_BITS'(5)
  };

  localparam logic [RECIP_BITS-1:0] RECIP [NUM_SLOTS] = '{
    RECIP_BITS'((1 << RECIP_SHIFT) / 1000), RECIP_BITS'((1 << RECIP_SHIFT) / 500),
    RECIP_BITS'((1 << RECIP_SHIFT) / 200),  RECIP_BITS'((1 << RECIP_SHIFT) / 100),
    RECIP_BITS'((1 << RECIP_SHIFT) / 50),   RECIP_BITS'((1 << RECIP_SHIFT) / 20),
    RECIP_BITS'((1 << RECIP_SHIFT) / 10),   RECIP_BITS'((1 << RECIP_SHIFT) / 5)
  };

  // operation codes
  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_CANCEL = 2'd2;
  localparam logic [1:0] OP_LOAD   = 2'd3;

  // result status codes
  localparam logic [3:0] ST_OWING        = 4'd0;
  localparam logic [3:0] ST_INVALID_COIN = 4'd1;
  localparam logic [3:0] ST_OUT_OF_STOCK = 4'd2;
  localparam logic [3:0] ST_STARTED      = 4'd3;
  localparam logic [3:0] ST_VEND_EXACT   = 4'd4;
  localparam logic [3:0] ST_VEND_CHANGE  = 4'd5;
  localparam logic [3:0] ST_VEND_SHORT   = 4'd6;
  localparam logic [3:0] ST_REFUND       = 4'd7;
  localparam logic [3:0] ST_CANCEL_NONE  = 4'd8;
  localparam logic [3:0] ST_NO_PURCHASE  = 4'd9;
  localparam logic [3:0] ST_LOADED       = 4'd10;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] price_cents;
    logic        item_in_stock;
    logic [15:0] coin_cents;
    logic [2:0]  stock_slot;
    logic [15:0] stock_count;
  } req_t;

  typedef struct packed {
    logic [3:0]            status;
    logic [15:0]           owing_cents;
    logic [AMT_BITS-1:0]   change_unpaid;
    logic [GIVEN_BITS-1:0] given_1000;
    logic [GIVEN_BITS-1:0] given_500;
    logic [GIVEN_BITS-1:0] given_200;
    logic [GIVEN_BITS-1:0] given_100;
    logic [GIVEN_BITS-1:0] given_50;
    logic [GIVEN_BITS-1:0] given_20;
    logic [GIVEN_BITS-1:0] given_10;
    logic [GIVEN_BITS-1:0] given_5;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic pay_mul;
    logic pay_quo;
    logic pay_sub;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_pay;
    logic last_slot;
  } stat_t;

endpackage

FILE: rtl/cpcd_ctrl.sv
// ----------------------------------------------------------------------------
// cpcd_ctrl
// Sequencer: takes one item, runs the execute step and, when something is paid
// out, the per-denomination payout steps, then hands the result to the output register.
// ----------------------------------------------------------------------------
module cpcd_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  input  cpcd_pkg::stat_t stat,
  output cpcd_pkg::cmd_t  cmd
);
  import cpcd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MUL,
    S_QUO,
    S_SUB,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE);

  always_comb begin
    cmd          = '0;
    state_next   = state;
    cmd.capture  = (state == S_IDLE) && req_valid;
    cmd.exec     = (state == S_EXEC);
    cmd.pay_mul  = (state == S_MUL);
    cmd.pay_quo  = (state == S_QUO);
    cmd.pay_sub  = (state == S_SUB);
    cmd.load_out = (state == S_FINISH) && out_free;
    case (state)
      S_IDLE:   if (req_valid) state_next = S_EXEC;
      S_EXEC:   state_next = stat.need_pay ? S_MUL : S_FINISH;
      S_MUL:    state_next = S_QUO;
      S_QUO:    state_next = S_SUB;
      S_SUB:    state_next = stat.last_slot ? S_FINISH : S_MUL;
      S_FINISH: if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/cpcd_dp.sv
// ----------------------------------------------------------------------------
// cpcd_dp
// Datapath: coin stock, purchase registers, greedy payout unit and the
// result register.
// ----------------------------------------------------------------------------
module cpcd_dp (
  input  logic           clk,
  input  logic           rst,
  input  cpcd_pkg::req_t req,
  input  cpcd_pkg::cmd_t cmd,
  output cpcd_pkg::stat_t stat,
  output cpcd_pkg::rsp_t rsp
);
  import cpcd_pkg::*;

  // architectural state
  logic [COUNT_BITS-1:0] stock [NUM_SLOTS];
  logic                  active;
  logic [15:0]           price_held;
  logic [15:0]           owing_held;
  logic [AMT_BITS-1:0]   paid_held;

  // per-item working registers
  req_t                  item;
  logic [3:0]            status_held;
  logic                  paying;
  logic [AMT_BITS-1:0]   amount;
  logic [SLOT_BITS-1:0]  slot;
  logic [PROD_BITS-1:0]  prod;
  logic [QUO_BITS-1:0]   quo;
  logic [GIVEN_BITS-1:0] given [NUM_SLOTS];

  // execute step decode
  logic                  coin_ok;
  logic [SLOT_BITS-1:0]  coin_idx;
  logic [AMT_BITS-1:0]   paid_sum;
  logic [AMT_BITS-1:0]   change;
  logic                  coin_lt;
  logic [3:0]            exec_status;
  logic                  exec_pay;
  logic [AMT_BITS-1:0]   exec_amount;
  logic [LOAD_BITS-1:0]  load_wide;
  logic [COUNT_BITS-1:0] load_sat;

  // payout step
  logic [SLOT_BITS-1:0]         rd_idx;
  logic [COUNT_BITS-1:0]        stock_rd;
  logic [AMT_BITS-1:0]          denom;
  logic [QUO_BITS-1:0]          quo0;
  logic [QUO_BITS+AMT_BITS-1:0] quo0_prod;
  logic [AMT_BITS-1:0]          rem0;
  logic [QUO_BITS-1:0]          take;
  logic [QUO_BITS+AMT_BITS-1:0] take_prod;

  always_comb begin
    coin_ok  = 1'b0;
    coin_idx = '0;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      if (AMT_BITS'(item.coin_cents) == DENOM[s]) begin
        coin_ok  = 1'b1;
        coin_idx = SLOT_BITS'(s);
      end
    end
  end

  assign paid_sum  = paid_held + AMT_BITS'(item.coin_cents);
  assign change    = paid_sum - AMT_BITS'(price_held);
  assign coin_lt   = item.coin_cents < owing_held;
  assign load_wide = LOAD_BITS'(item.stock_count);
  assign load_sat  = (load_wide > LOAD_BITS'(CNT_MAX)) ? CNT_MAX : COUNT_BITS'(load_wide);

  always_comb begin
    exec_status = ST_LOADED;
    exec_pay    = 1'b0;
    exec_amount = change;
    case (item.operation)
      OP_START: begin
        exec_status = item.item_in_stock ? ST_STARTED : ST_OUT_OF_STOCK;
      end
      OP_INSERT: begin
        if (!active) begin
          exec_status = ST_NO_PURCHASE;
        end else if (!coin_ok) begin
          exec_status = ST_INVALID_COIN;
        end else if (coin_lt) begin
          exec_status = ST_OWING;
        end else if (change == '0) begin
          exec_status = ST_VEND_EXACT;
        end else begin
          exec_status = ST_VEND_CHANGE;
          exec_pay    = 1'b1;
        end
      end
      OP_CANCEL: begin
        exec_amount = paid_held;
        if (!active) begin
          exec_status = ST_NO_PURCHASE;
        end else if (paid_held == '0) begin
          exec_status = ST_CANCEL_NONE;
        end else begin
          exec_status = ST_REFUND;
          exec_pay    = 1'b1;
        end
      end
      default: exec_status = ST_LOADED;
    endcase
  end

  assign stat.need_pay  = exec_pay;
  assign stat.last_slot = (slot == SLOT_BITS'(NUM_SLOTS - 1));

  // single read port, shared by the coin deposit and the payout walk
  assign rd_idx   = cmd.exec ? coin_idx : slot;
  assign stock_rd = stock[rd_idx];
  assign denom    = DENOM[slot];

  // reciprocal estimate is exact or one low
  assign quo0      = QUO_BITS'(prod >> RECIP_SHIFT);
  assign quo0_prod = quo0 * denom;
  assign rem0      = amount - AMT_BITS'(quo0_prod);

  assign take      = (CMP_BITS'(quo) <= CMP_BITS'(stock_rd)) ? quo : QUO_BITS'(stock_rd);
  assign take_prod = take * denom;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        stock[s] <= '0;
      end
      active     <= 1'b0;
      price_held <= '0;
      owing_held <= '0;
      paid_held  <= '0;
    end else begin
      if (cmd.exec) begin
        case (item.operation)
          OP_START: begin
            active     <= item.item_in_stock;
            price_held <= item.item_in_stock ? item.price_cents : '0;
            owing_held <= item.item_in_stock ? item.price_cents : '0;
            paid_held  <= '0;
          end
          OP_INSERT: begin
            if (active && coin_ok) begin
              if (stock_rd != CNT_MAX) begin
                stock[coin_idx] <= stock_rd + COUNT_BITS'(1);
              end
              if (coin_lt) begin
                paid_held  <= paid_sum;
                owing_held <= owing_held - item.coin_cents;
              end else begin
                active     <= 1'b0;
                price_held <= '0;
                owing_held <= '0;
                paid_held  <= '0;
              end
            end
          end
          OP_CANCEL: begin
            if (active) begin
              active     <= 1'b0;
              price_held <= '0;
              owing_held <= '0;
              paid_held  <= '0;
            end
          end
          default: stock[item.stock_slot] <= load_sat;
        endcase
      end
      if (cmd.pay_sub) begin
        stock[slot] <= COUNT_BITS'(CMP_BITS'(stock_rd) - CMP_BITS'(take));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= req;
      for (int s = 0; s < NUM_SLOTS; s++) begin
        given[s] <= '0;
      end
    end
    if (cmd.exec) begin
      status_held <= exec_status;
      paying      <= exec_pay;
      amount      <= exec_amount;
      slot        <= '0;
    end
    if (cmd.pay_mul) begin
      prod <= amount * RECIP[slot];
    end
    if (cmd.pay_quo) begin
      quo <= (rem0 >= denom) ? quo0 + QUO_BITS'(1) : quo0;
    end
    if (cmd.pay_sub) begin
      amount      <= amount - AMT_BITS'(take_prod);
      given[slot] <= GIVEN_BITS'(take);
      slot        <= slot + SLOT_BITS'(1);
    end
    if (cmd.load_out) begin
      rsp.status        <= (paying && amount != '0 && status_held == ST_VEND_CHANGE)
                           ? ST_VEND_SHORT : status_held;
      rsp.owing_cents   <= active ? owing_held : '0;
      rsp.change_unpaid <= paying ? amount : '0;
      rsp.given_1000    <= given[0];
      rsp.given_500     <= given[1];
      rsp.given_200     <= given[2];
      rsp.given_100     <= given[3];
      rsp.given_50      <= given[4];
      rsp.given_20      <= given[5];
      rsp.given_10      <= given[6];
      rsp.given_5       <= given[7];
    end
  end

endmodule

FILE: rtl/coin_payment_and_change_dispenser_unit.sv
// ----------------------------------------------------------------------------
// coin_payment_and_change_dispenser_unit
// Coin changer with per-denomination stock and greedy change payout.
// ----------------------------------------------------------------------------
// Each item passes through capture, execute and the result register when nothing
// is paid out. A vend with change or a refund with money paid walks the eight
// denominations in turn through one shared divide-and-take unit, each one
// through reciprocal multiply, quotient correction, and take and subtract.
// The next item is accepted as soon as the result is in the output register,
// even while that result is still stalled; an item waits in its last step
// only when the previous result has not yet been taken.
module coin_payment_and_change_dispenser_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  cpcd_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output cpcd_pkg::rsp_t rsp
);
  import cpcd_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  cpcd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  cpcd_dp u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cmd  (cmd),
    .stat (stat),
    .rsp  (rsp)
  );

  // one item in work at a time
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("item accepted while another is in work");

  // coins only leave on a vend with change or a refund
  a_given_only_on_payout: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != ST_VEND_CHANGE && rsp.status != ST_VEND_SHORT &&
     rsp.status != ST_REFUND) |->
    (rsp.given_1000 == '0 && rsp.given_500 == '0 && rsp.given_200 == '0 &&
     rsp.given_100 == '0 && rsp.given_50 == '0 && rsp.given_20 == '0 &&
     rsp.given_10 == '0 && rsp.given_5 == '0))
    else $error("coins reported without a payout");

  // unpaid change only on a short vend or a refund
  a_unpaid_status: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.change_unpaid != '0) |->
    (rsp.status == ST_VEND_SHORT || rsp.status == ST_REFUND))
    else $error("unpaid change with wrong status");

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the coin changer: a stimulus table for the corner
// cases, then biased random purchases, coins, cancels and stock loads, with
// every receipt checked against a cycle-free model of stock and payout.
// ----------------------------------------------------------------------------
module testbench;
  import cpcd_pkg::*;

  localparam int RANDOM_ITEMS  = 1500;
  localparam int WATCHDOG_MAX  = 3000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    req_t item;
    bit   fixed;
    rsp_t want;
  } step_t;

  logic clk;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  // model state
  logic [COUNT_BITS-1:0] stock_cnt [NUM_SLOTS];
  logic [GIVEN_BITS-1:0] coins_out [NUM_SLOTS];
  logic                  buying;
  logic [15:0]           price_reg;
  logic [15:0]           owing_reg;
  logic [AMT_BITS-1:0]   paid_reg;

  rsp_t  receipts_due [$];
  step_t table_rows [$];
  rsp_t  head;
  int    bad_count;
  int    idle_cycles;
  bit    quiet;
  bit    hold_request;
  int    hold_left;

  coin_payment_and_change_dispenser_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void close_purchase();
    buying    = 1'b0;
    price_reg = '0;
    owing_reg = '0;
    paid_reg  = '0;
  endfunction

  // largest coin first, as many as fit and are stocked
  function automatic logic [AMT_BITS-1:0] pay_greedy(input logic [AMT_BITS-1:0] amt);
    int unsigned want_n;
    int unsigned take;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      want_n = amt / DENOM[s];
      take = (want_n < stock_cnt[s]) ? want_n : stock_cnt[s];
      stock_cnt[s] = stock_cnt[s] - COUNT_BITS'(take);
      amt = amt - AMT_BITS'(take * DENOM[s]);
      coins_out[s] = GIVEN_BITS'(take);
    end
    return amt;
  endfunction

  function automatic rsp_t compute_receipt(input req_t r);
    rsp_t                o;
    int                  idx;
    logic [AMT_BITS-1:0] unpaid;
    logic [AMT_BITS-1:0] change;
    o = '0;
    unpaid = '0;
    for (int s = 0; s < NUM_SLOTS; s++) coins_out[s] = '0;
    case (r.operation)
      OP_START: begin
        if (!r.item_in_stock) begin
          close_purchase();
          o.status = ST_OUT_OF_STOCK;
        end else begin
          buying    = 1'b1;
          price_reg = r.price_cents;
          owing_reg = r.price_cents;
          paid_reg  = '0;
          o.status  = ST_STARTED;
        end
      end
      OP_INSERT: begin
        if (!buying) begin
          o.status = ST_NO_PURCHASE;
        end else begin
          idx = -1;
          for (int s = 0; s < NUM_SLOTS; s++)
            if (AMT_BITS'(r.coin_cents) == DENOM[s]) idx = s;
          if (idx < 0) begin
            o.status = ST_INVALID_COIN;
          end else begin
            if (stock_cnt[idx] != CNT_MAX) stock_cnt[idx] = stock_cnt[idx] + 1'b1;
            paid_reg = paid_reg + AMT_BITS'(r.coin_cents);
            if (r.coin_cents < owing_reg) begin
              owing_reg = owing_reg - r.coin_cents;
              o.status = ST_OWING;
            end else begin
              change = paid_reg - AMT_BITS'(price_reg);
              if (change == '0) begin
                o.status = ST_VEND_EXACT;
              end else begin
                unpaid = pay_greedy(change);
                o.status = (unpaid != '0) ? ST_VEND_SHORT : ST_VEND_CHANGE;
              end
              close_purchase();
            end
          end
        end
      end
      OP_CANCEL: begin
        if (!buying) begin
          o.status = ST_NO_PURCHASE;
        end else if (paid_reg == '0) begin
          o.status = ST_CANCEL_NONE;
          close_purchase();
        end else begin
          unpaid = pay_greedy(paid_reg);
          o.status = ST_REFUND;
          close_purchase();
        end
      end
      default: begin
        stock_cnt[r.stock_slot] = (r.stock_count < CNT_MAX) ? r.stock_count : CNT_MAX;
        o.status = ST_LOADED;
      end
    endcase
    o.owing_cents   = buying ? owing_reg : 16'd0;
    o.change_unpaid = unpaid;
    o.given_1000    = coins_out[0];
    o.given_500     = coins_out[1];
    o.given_200     = coins_out[2];
    o.given_100     = coins_out[3];
    o.given_50      = coins_out[4];
    o.given_20      = coins_out[5];
    o.given_10      = coins_out[6];
    o.given_5       = coins_out[7];
    return o;
  endfunction

  function automatic step_t row(input logic [1:0] op, input logic [15:0] price,
                                input logic ins, input logic [15:0] coin,
                                input logic [2:0] slot, input logic [15:0] cnt,
                                input bit fixed, input logic [3:0] st,
                                input logic [15:0] owing);
    step_t t;
    t.item = '0;
    t.item.operation     = op;
    t.item.price_cents   = price;
    t.item.item_in_stock = ins;
    t.item.coin_cents    = coin;
    t.item.stock_slot    = slot;
    t.item.stock_count   = cnt;
    t.fixed = fixed;
    t.want = '0;
    t.want.status      = st;
    t.want.owing_cents = owing;
    return t;
  endfunction

  // mostly well-formed traffic: starts, real coins, some cancels, small loads
  function automatic req_t random_item();
    req_t r;
    int   pick;
    r.operation     = OP_LOAD;
    r.price_cents   = 16'($urandom);
    r.item_in_stock = 1'($urandom);
    r.coin_cents    = 16'($urandom);
    r.stock_slot    = 3'($urandom);
    r.stock_count   = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 14) begin
      r.operation = OP_START;
      r.item_in_stock = ($urandom_range(9) != 0);
      pick = $urandom_range(99);
      if (pick < 60) r.price_cents = 16'($urandom_range(0, 400) * 5);
      else if (pick < 85) r.price_cents = 16'($urandom_range(0, 3000));
    end else if (pick < 74) begin
      r.operation = OP_INSERT;
      pick = $urandom_range(99);
      if (pick < 88) r.coin_cents = 16'(DENOM[$urandom_range(NUM_SLOTS - 1)]);
      else if (pick < 92) r.coin_cents = '0;
    end else if (pick < 82) begin
      r.operation = OP_CANCEL;
    end else begin
      pick = $urandom_range(99);
      if (pick < 50) r.stock_count = 16'($urandom_range(0, 8));
      else if (pick < 80) r.stock_count = 16'($urandom_range(0, 500));
      else if (pick < 90) r.stock_count = CNT_MAX;
    end
    return r;
  endfunction

  task automatic send_item(input step_t t);
    rsp_t predicted;
    while (!quiet && $urandom_range(99) < 22) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req       <= t.item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predicted = compute_receipt(t.item);
    receipts_due.push_back(t.fixed ? t.want : predicted);
  endtask

  task automatic wait_drained();
    while (receipts_due.size() != 0) @(posedge clk);
  endtask

  // receiver side: random stalls, quiet stretch, one long hold-off
  initial begin
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= !quiet && ($urandom_range(99) < 22);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (receipts_due.size() == 0) begin
        bad_count++;
        if (bad_count <= 10) $display("unexpected receipt: status %0d", rsp.status);
      end else begin
        head = receipts_due.pop_front();
        if (rsp !== head) begin
          bad_count++;
          if (bad_count <= 10) begin
            $display("mismatch: status/owing/unpaid exp %0d/%0d/%0d got %0d/%0d/%0d",
                     head.status, head.owing_cents, head.change_unpaid,
                     rsp.status, rsp.owing_cents, rsp.change_unpaid);
            $display("  coins exp %0d %0d %0d %0d %0d %0d %0d %0d",
                     head.given_1000, head.given_500, head.given_200, head.given_100,
                     head.given_50, head.given_20, head.given_10, head.given_5);
            $display("  coins got %0d %0d %0d %0d %0d %0d %0d %0d",
                     rsp.given_1000, rsp.given_500, rsp.given_200, rsp.given_100,
                     rsp.given_50, rsp.given_20, rsp.given_10, rsp.given_5);
          end
        end
      end
    end
  end

  // ends a hung run: counts cycles with no item moving on either side
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_MAX) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    bad_count    = 0;
    idle_cycles  = 0;
    quiet        = 1'b0;
    hold_request = 1'b0;
    for (int s = 0; s < NUM_SLOTS; s++) stock_cnt[s] = '0;
    close_purchase();

    // op, price, in stock, coin, slot, count, fixed, status, owing
    table_rows.push_back(row(OP_INSERT, 0, 0, 5, 0, 0, 1, ST_NO_PURCHASE, 0));
    table_rows.push_back(row(OP_CANCEL, 0, 0, 0, 0, 0, 1, ST_NO_PURCHASE, 0));
    table_rows.push_back(row(OP_START, 100, 0, 0, 0, 0, 1, ST_OUT_OF_STOCK, 0));
    table_rows.push_back(row(OP_LOAD, 0, 0, 0, 0, 16'hffff, 1, ST_LOADED, 0));
    table_rows.push_back(row(OP_LOAD, 0, 0, 0, 7, 0, 1, ST_LOADED, 0));
    table_rows.push_back(row(OP_LOAD, 0, 0, 0, 4, 3, 1, ST_LOADED, 0));
    table_rows.push_back(row(OP_START, 16'hffff, 1, 0, 0, 0, 1, ST_STARTED, 16'hffff));
    table_rows.push_back(row(OP_INSERT, 0, 0, 0, 0, 0, 1, ST_INVALID_COIN, 16'hffff));
    table_rows.push_back(row(OP_INSERT, 0, 0, 16'hffff, 0, 0, 1, ST_INVALID_COIN,
                             16'hffff));
    table_rows.push_back(row(OP_INSERT, 0, 0, 1000, 0, 0, 1, ST_OWING, 64535));
    // refund from a saturated slot
    table_rows.push_back(row(OP_CANCEL, 0, 0, 0, 0, 0, 0, 0, 0));
    // zero price: the first coin comes straight back
    table_rows.push_back(row(OP_START, 0, 1, 0, 0, 0, 1, ST_STARTED, 0));
    table_rows.push_back(row(OP_INSERT, 0, 0, 5, 0, 0, 0, 0, 0));
    table_rows.push_back(row(OP_START, 105, 1, 0, 0, 0, 1, ST_STARTED, 105));
    table_rows.push_back(row(OP_INSERT, 0, 0, 100, 0, 0, 1, ST_OWING, 5));
    table_rows.push_back(row(OP_INSERT, 0, 0, 5, 0, 0, 1, ST_VEND_EXACT, 0));
    // change that stock cannot cover
    table_rows.push_back(row(OP_START, 5, 1, 0, 0, 0, 1, ST_STARTED, 5));
    table_rows.push_back(row(OP_INSERT, 0, 0, 50, 0, 0, 0, 0, 0));
    // restart drops the open purchase
    table_rows.push_back(row(OP_START, 300, 1, 0, 0, 0, 1, ST_STARTED, 300));
    table_rows.push_back(row(OP_START, 200, 0, 0, 0, 0, 1, ST_OUT_OF_STOCK, 0));
    table_rows.push_back(row(OP_CANCEL, 0, 0, 0, 0, 0, 1, ST_NO_PURCHASE, 0));
    table_rows.push_back(row(OP_START, 20, 1, 0, 0, 0, 1, ST_STARTED, 20));
    table_rows.push_back(row(OP_CANCEL, 0, 0, 0, 0, 0, 1, ST_CANCEL_NONE, 0));
    table_rows.push_back(row(OP_LOAD, 0, 0, 0, 3, 40000, 1, ST_LOADED, 0));
    table_rows.push_back(row(OP_START, 1, 1, 0, 0, 0, 1, ST_STARTED, 1));
    table_rows.push_back(row(OP_INSERT, 0, 0, 200, 0, 0, 0, 0, 0));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (table_rows[i]) send_item(table_rows[i]);
    req_valid <= 1'b0;
    wait_drained();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 300) quiet = 1'b1;
      if (i == 600) quiet = 1'b0;
      // receiver holds off while items keep coming, so the input backs up
      if (i == 900) hold_request = 1'b1;
      if (i == 1200) begin
        req_valid <= 1'b0;
        @(posedge clk);
        wait_drained();
      end
      send_item('{item: random_item(), fixed: 1'b0, want: '0});
    end
    req_valid <= 1'b0;

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (bad_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: coin_payment_and_change_dispenser_unit.f
rtl/cpcd_pkg.sv
rtl/cpcd_ctrl.sv
rtl/cpcd_dp.sv
rtl/coin_payment_and_change_dispenser_unit.sv
verif/testbench.sv
